// ----- design/ptb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ptb_pkg;

   localparam int NUM_TIMERS_DEF = 8;
   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   typedef enum logic [2:0] {
      OP_CHECK = 3'd0,
      OP_SET   = 3'd1,
      OP_ALLOC = 3'd2,
      OP_KILL  = 3'd3,
      OP_QUERY = 3'd4,
      OP_OTHER = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      KIND_FIRED  = 3'd0,
      KIND_ALLOC  = 3'd1,
      KIND_FAIL   = 3'd2,
      KIND_REMAIN = 3'd3,
      KIND_DONE   = 3'd4
   } kind_type;

   typedef struct packed {
      op_type             op;
      logic               slot_ok;
      logic [2:0]         slot;
      logic [31:0]        now;
      logic [31:0]        period;
      logic signed [16:0] count;
   } cmd_type;

   typedef struct packed {
      logic [31:0]        start;
      logic [31:0]        intv;
      logic signed [16:0] count;
   } entry_type;

   typedef struct packed {
      kind_type           kind;
      logic [2:0]         slot_out;
      logic signed [32:0] remaining;
      logic               last;
   } rsp_type;

endpackage
`default_nettype wire

// ----- design/periodic_timer_bank_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Bank of NUM_TIMERS periodic timers behind two queue-style ports. Commands
// enter a two-word queue; a sequencer executes them against a timer table
// with one registered read per cycle. A check or allocate walks the slots in
// order, one slot per cycle while results can be queued: a check dequeues,
// visits every slot, then sends a final done word; an allocate stops at the
// first free slot or the last slot. Results wait in a two-word queue; while
// it is full the sequencer holds its result steps. Per-slot valid bits make
// unwritten slots read as unused, so the table is usable straight out of reset.
module periodic_timer_bank_unit #(
   parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic [2:0]         req_opcode,
   input  wire logic [31:0]        req_now,
   input  wire logic [2:0]         req_slot,
   input  wire logic [31:0]        req_period,
   input  wire logic signed [16:0] req_repeat_count,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic [2:0]              rsp_kind,
   output logic [2:0]              rsp_slot_out,
   output logic signed [32:0]      rsp_remaining,
   output logic                    rsp_last
);

   logic             cmd_valid, cmd_pop;
   ptb_pkg::cmd_type cmd_word;
   logic             out_full, out_push;
   ptb_pkg::rsp_type out_word, head;

   ptb_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_opcode       (req_opcode),
      .req_now          (req_now),
      .req_slot         (req_slot),
      .req_period       (req_period),
      .req_repeat_count (req_repeat_count),
      .cmd_pop          (cmd_pop),
      .cmd_valid        (cmd_valid),
      .cmd_word         (cmd_word)
   );

   ptb_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_word  (cmd_word),
      .cmd_pop   (cmd_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_word  (out_word)
   );

   ptb_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_word (out_word),
      .full      (out_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (head)
   );

   assign rsp_kind      = head.kind;
   assign rsp_slot_out  = head.slot_out;
   assign rsp_remaining = head.remaining;
   assign rsp_last      = head.last;

endmodule
`default_nettype wire

// ----- design/ptb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ptb_front #(
   parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic [2:0]         req_opcode,
   input  wire logic [31:0]        req_now,
   input  wire logic [2:0]         req_slot,
   input  wire logic [31:0]        req_period,
   input  wire logic signed [16:0] req_repeat_count,
   input  wire logic               cmd_pop,
   output logic                    cmd_valid,
   output ptb_pkg::cmd_type        cmd_word
);

   ptb_pkg::cmd_type cmd_q_ff [ptb_pkg::CMD_DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   ptb_pkg::cmd_type word_in;
   logic             push_ok, pop_ok;

   always_comb begin
      word_in = '0;
      unique case (req_opcode)
         ptb_pkg::OP_CHECK: word_in.op = ptb_pkg::OP_CHECK;
         ptb_pkg::OP_SET:   word_in.op = ptb_pkg::OP_SET;
         ptb_pkg::OP_ALLOC: word_in.op = ptb_pkg::OP_ALLOC;
         ptb_pkg::OP_KILL:  word_in.op = ptb_pkg::OP_KILL;
         ptb_pkg::OP_QUERY: word_in.op = ptb_pkg::OP_QUERY;
         default: word_in.op = ptb_pkg::OP_OTHER;
      endcase
      word_in.slot_ok = (int'(req_slot) < NUM_TIMERS);
      word_in.slot    = req_slot;
      word_in.now     = req_now;
      word_in.period  = req_period;
      word_in.count   = req_repeat_count;
   end

   assign req_full  = (fill_ff == 2'(ptb_pkg::CMD_DEPTH));
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd_word  = cmd_q_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         cmd_q_ff[wr_ptr_ff] <= word_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/ptb_rsp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ptb_rsp_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire ptb_pkg::rsp_type push_word,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output ptb_pkg::rsp_type      head
);

   ptb_pkg::rsp_type rsp_q_ff [ptb_pkg::RSP_DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             push_ok, pop_ok;

   assign full    = (fill_ff == 2'(ptb_pkg::RSP_DEPTH));
   assign empty   = (fill_ff == 2'd0);
   assign head    = rsp_q_ff[rd_ptr_ff];
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;

   always_comb begin
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         rsp_q_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule
`default_nettype wire

// ----- design/ptb_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ptb_back #(
   parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   input  wire ptb_pkg::cmd_type cmd_word,
   output logic                  cmd_pop,
   input  wire logic             out_full,
   output logic                  out_push,
   output ptb_pkg::rsp_type      out_word
);

   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   ptb_pkg::cmd_type   cmd_ff, cmd_in;
   logic [IW-1:0]      idx_ff, idx_in;

   ptb_pkg::entry_type mem [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] valid_ff;
   ptb_pkg::entry_type rd_data_ff;
   logic               rd_valid_ff;

   logic               rd_en, wr_en;
   logic [IW-1:0]      rd_addr, wr_addr;
   ptb_pkg::entry_type wr_data, cur;

   logic [32:0]        due;
   logic [33:0]        diff;
   logic               fire, at_last, free;

   assign cur     = rd_valid_ff ? rd_data_ff : '0;
   assign due     = {1'b0, cur.start} + {1'b0, cur.intv};
   assign diff    = {1'b0, due} - {2'b00, cmd_ff.now};
   assign fire    = (cur.count != 17'sd0) && (due <= {1'b0, cmd_ff.now});
   assign free    = (cur.count == 17'sd0);
   assign at_last = (idx_ff == LAST_IDX);

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      idx_in   = idx_ff;
      cmd_pop  = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = idx_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = '0;
      out_push = 1'b0;
      out_word = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_word;
               rd_en    = 1'b1;
               rd_addr  = ((cmd_word.op == ptb_pkg::OP_CHECK) ||
                           (cmd_word.op == ptb_pkg::OP_ALLOC)) ? '0 : IW'(cmd_word.slot);
               idx_in   = rd_addr;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!out_full) begin
               unique case (cmd_ff.op)
                  ptb_pkg::OP_CHECK: begin
                     if (fire) begin
                        wr_en               = 1'b1;
                        wr_data.start       = cur.start + cur.intv;
                        wr_data.intv        = cur.intv;
                        wr_data.count       = cur.count[16] ? cur.count
                                                            : cur.count - 17'sd1;
                        out_push            = 1'b1;
                        out_word.kind       = ptb_pkg::KIND_FIRED;
                        out_word.slot_out   = 3'(idx_ff);
                     end
                     if (at_last) begin
                        state_in = ST_FIN;
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = idx_ff + 1'b1;
                        idx_in  = rd_addr;
                     end
                  end
                  ptb_pkg::OP_ALLOC: begin
                     if (free) begin
                        wr_en             = 1'b1;
                        wr_data.start     = cmd_ff.now;
                        wr_data.intv      = cmd_ff.period;
                        wr_data.count     = cmd_ff.count;
                        out_push          = 1'b1;
                        out_word.kind     = ptb_pkg::KIND_ALLOC;
                        out_word.slot_out = 3'(idx_ff);
                        out_word.last     = 1'b1;
                        state_in          = ST_IDLE;
                     end else if (at_last) begin
                        out_push      = 1'b1;
                        out_word.kind = ptb_pkg::KIND_FAIL;
                        out_word.last = 1'b1;
                        state_in      = ST_IDLE;
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = idx_ff + 1'b1;
                        idx_in  = rd_addr;
                     end
                  end
                  ptb_pkg::OP_SET: begin
                     wr_en             = cmd_ff.slot_ok;
                     wr_data.start     = cmd_ff.now;
                     wr_data.intv      = cmd_ff.period;
                     wr_data.count     = cmd_ff.count;
                     out_push          = 1'b1;
                     out_word.kind     = ptb_pkg::KIND_DONE;
                     out_word.slot_out = cmd_ff.slot;
                     out_word.last     = 1'b1;
                     state_in          = ST_IDLE;
                  end
                  ptb_pkg::OP_KILL: begin
                     wr_en             = cmd_ff.slot_ok;
                     out_push          = 1'b1;
                     out_word.kind     = ptb_pkg::KIND_DONE;
                     out_word.slot_out = cmd_ff.slot;
                     out_word.last     = 1'b1;
                     state_in          = ST_IDLE;
                  end
                  ptb_pkg::OP_QUERY: begin
                     out_push          = 1'b1;
                     out_word.kind     = ptb_pkg::KIND_REMAIN;
                     out_word.slot_out = cmd_ff.slot;
                     out_word.last     = 1'b1;
                     if (cmd_ff.slot_ok) begin
                        out_word.remaining = (!diff[33] && diff[32]) ? 33'sh0_FFFF_FFFF
                                                                     : diff[32:0];
                     end
                     state_in = ST_IDLE;
                  end
                  default: begin
                     out_push      = 1'b1;
                     out_word.kind = ptb_pkg::KIND_DONE;
                     out_word.last = 1'b1;
                     state_in      = ST_IDLE;
                  end
               endcase
            end
         end
         ST_FIN: begin
            if (!out_full) begin
               out_push      = 1'b1;
               out_word.kind = ptb_pkg::KIND_DONE;
               out_word.last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

endmodule
`default_nettype wire
